// File: sv/base64url_unpadded_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for base64url_unpadded_decoder
// Implication checks, same cycle and next cycle, on i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef BASE64URL_UNPADDED_DECODER_ASSERT_SVH
`define BASE64URL_UNPADDED_DECODER_ASSERT_SVH

// same-cycle implication
`define B64D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants shared by the base64url decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // character codes bounding the alphabet ranges
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_USCR  = 8'h5F;

    // sextet offsets
    localparam logic [7:0] OFS_LOWER = 8'd26;
    localparam logic [7:0] OFS_DIGIT = 8'd52;
    localparam logic [5:0] SX_DASH   = 6'd62;
    localparam logic [5:0] SX_USCR   = 6'd63;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_NONCANON = 2'd2
    } t_status;

    // number of leftover bits held: 0, 2, 4 or 6
    typedef enum logic [1:0] {
        FILL_0 = 2'd0,
        FILL_2 = 2'd1,
        FILL_4 = 2'd2,
        FILL_6 = 2'd3
    } t_fill;

    typedef struct packed {
        logic [7:0] symbol;
        logic       final_symbol;
    } t_in_req;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        t_status    status;
        logic       message_done;
    } t_out_req;

    // one decode step: whether a result leaves, and the result
    typedef struct packed {
        logic     emit;
        t_out_req res;
    } t_step;

endpackage

// File: sv/b64d_sextet_map.sv
// ----------------------------------------------------------------------------
// b64d_sextet_map
// Maps one url-safe base64 character to its six-bit value.
// ----------------------------------------------------------------------------
module b64d_sextet_map (
    input  logic [7:0] i_symbol,
    output logic       o_ok,
    output logic [5:0] o_sextet
);
    import b64d_pkg::*;

    logic [7:0] w_tmp;

    always_comb begin
        o_ok  = 1'b1;
        w_tmp = 8'd0;
        if (i_symbol inside {[CH_UP_A:CH_UP_Z]}) begin
            w_tmp = i_symbol - CH_UP_A;
        end else if (i_symbol inside {[CH_LO_A:CH_LO_Z]}) begin
            w_tmp = i_symbol - CH_LO_A + OFS_LOWER;
        end else if (i_symbol inside {[CH_DIG_0:CH_DIG_9]}) begin
            w_tmp = i_symbol - CH_DIG_0 + OFS_DIGIT;
        end else if (i_symbol == CH_DASH) begin
            w_tmp = {2'b00, SX_DASH};
        end else if (i_symbol == CH_USCR) begin
            w_tmp = {2'b00, SX_USCR};
        end else begin
            o_ok = 1'b0;
        end
        o_sextet = w_tmp[5:0];
    end

endmodule

// File: sv/b64d_accum.sv
// ----------------------------------------------------------------------------
// b64d_accum
// Bit accumulator and message state; computes one decode step per item.
// ----------------------------------------------------------------------------
module b64d_accum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b64d_pkg::t_in_req i_item,
    input  logic             i_advance,
    output b64d_pkg::t_step  o_step
);
    import b64d_pkg::*;

    logic [5:0] r_bits, n_bits;
    t_fill      r_fill, n_fill;
    logic       r_disc, n_disc;

    logic       w_ok;
    logic [5:0] w_sx;

    b64d_sextet_map u_map (
        .i_symbol (i_item.symbol),
        .o_ok     (w_ok),
        .o_sextet (w_sx)
    );

    always_comb begin
        o_step = '0;
        n_bits = r_bits;
        n_fill = r_fill;
        n_disc = r_disc;
        if (r_disc) begin
            // dropping the rest of a bad message
            if (i_item.final_symbol) begin
                n_disc = 1'b0;
            end
        end else if (!w_ok) begin
            o_step.emit             = 1'b1;
            o_step.res.status       = ST_BAD_CHAR;
            o_step.res.message_done = 1'b1;
            n_bits = '0;
            n_fill = FILL_0;
            n_disc = !i_item.final_symbol;
        end else begin
            case (r_fill)
                FILL_0: begin
                    n_bits = w_sx;
                    n_fill = FILL_6;
                    if (i_item.final_symbol) begin
                        o_step.emit             = 1'b1;
                        o_step.res.message_done = 1'b1;
                        o_step.res.status       = (w_sx != 6'd0) ? ST_NONCANON : ST_OK;
                    end
                end
                FILL_2: begin
                    o_step.emit           = 1'b1;
                    o_step.res.byte_valid = 1'b1;
                    o_step.res.data_byte  = {r_bits[1:0], w_sx};
                    n_bits = '0;
                    n_fill = FILL_0;
                end
                FILL_4: begin
                    o_step.emit           = 1'b1;
                    o_step.res.byte_valid = 1'b1;
                    o_step.res.data_byte  = {r_bits[3:0], w_sx[5:2]};
                    n_bits = {4'd0, w_sx[1:0]};
                    n_fill = FILL_2;
                end
                FILL_6: begin
                    o_step.emit           = 1'b1;
                    o_step.res.byte_valid = 1'b1;
                    o_step.res.data_byte  = {r_bits, w_sx[5:4]};
                    n_bits = {2'd0, w_sx[3:0]};
                    n_fill = FILL_4;
                end
                default: begin
                    n_fill = FILL_0;
                end
            endcase
            if (o_step.res.byte_valid) begin
                o_step.res.message_done = i_item.final_symbol;
            end
            if (i_item.final_symbol) begin
                n_bits = '0;
                n_fill = FILL_0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_fill <= FILL_0;
            r_disc <= 1'b0;
        end else if (i_advance) begin
            r_bits <= n_bits;
            r_fill <= n_fill;
            r_disc <= n_disc;
        end
    end

endmodule

// File: sv/base64url_unpadded_decoder.sv
// ----------------------------------------------------------------------------
// base64url_unpadded_decoder
// Streaming decoder for unpadded url-safe base64, one character per request.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in): one character per request,
// with final_symbol set on the last character of a message.
// Output channel (o_out_valid / i_out_ready / o_out): at most one result per
// character: a decoded byte, or a status-only result that ends the message
// (bad character, non-canonical leftover, or a plain end with no byte).
// Characters that form no byte and do not end the message give no result;
// after a bad character the rest of the message is dropped silently.
// Path: a taken character is held in the input register, decoded from there,
// and then lands in the output register.
// Throughput: one character per cycle unless stalled. The accumulator state
// updates in the same cycle that the character leaves the input register.
// Stall: when the output register is full and not taken, a character that
// would produce a result waits in the input register; o_in_ready then drops
// until the output drains. Characters giving no result still pass.
// Reset (i_rst_n low, synchronous): both registers empty, accumulator and
// discard state cleared.
// ----------------------------------------------------------------------------
module base64url_unpadded_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  b64d_pkg::t_in_req i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output b64d_pkg::t_out_req o_out
);
    import b64d_pkg::*;

    `include "base64url_unpadded_decoder_assert.svh"

    // input register
    logic     r_in_valid;
    t_in_req  r_in;
    // output register
    logic     r_out_valid;
    t_out_req r_out;

    t_step    w_step;
    logic     w_advance;

    b64d_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_in),
        .i_advance (w_advance),
        .o_step    (w_step)
    );

    // the held character moves on unless it needs the output slot and the
    // slot is occupied and not being drained
    assign w_advance  = r_in_valid && (!w_step.emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_step.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_step.emit) begin
            r_out <= w_step.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a decoded byte never carries an error
    `B64D_ASSERT_NOW(a_byte_ok, o_out_valid && o_out.byte_valid, o_out.status == ST_OK, "byte with error status")
    // any error status ends the message
    `B64D_ASSERT_NOW(a_err_done, o_out_valid && (o_out.status != ST_OK), o_out.message_done, "error without message end")
    // a blocked character stays in the input register
    `B64D_ASSERT_NEXT(a_in_hold, r_in_valid && !w_advance, r_in_valid && $stable(r_in), "blocked input lost")

endmodule
